// ----- design/mkme_pkg.sv -----
// Shared types, codes and constants of the mouse-keys motion engine.
package mkme_pkg;

    // Reset values of the configuration registers.
    localparam logic [7:0] SCALE_LIMIT_RESET        = 8'd20;
    localparam logic [7:0] FAST_POINTER_SCALE_RESET = 8'd10;
    localparam logic [7:0] FAST_SCROLL_SCALE_RESET  = 8'd5;
    localparam logic [5:0] SCROLL_UNIT_RESET        = 6'd1;

    localparam int NUM_BUTTONS_DEFAULT = 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCALE_LIMIT        = 2'd0;
    localparam logic [1:0] CFG_FAST_POINTER_SCALE = 2'd1;
    localparam logic [1:0] CFG_FAST_SCROLL_SCALE  = 2'd2;
    localparam logic [1:0] CFG_SCROLL_UNIT        = 2'd3;

    // Virtual-key codes and item modes.
    localparam logic [4:0] KEY_HIGH_SPEED   = 5'd8;
    localparam logic [4:0] KEY_FIRST_BUTTON = 5'd9;
    localparam logic       MODE_TICK        = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_POINTER = 2'd1,
        KIND_SCROLL  = 2'd2
    } report_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted input transaction
        logic execute;   // update state and form the first products
        logic publish;   // form the final products into the output register
    } dp_cmd_t;

endpackage

// ----- design/mkme_ctrl.sv -----
// Controller state machine: sequences capture, execute and publish steps.
module mkme_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mkme_pkg::dp_cmd_t cmd
);

    mkme_pkg::ctrl_state_t state_reg;
    mkme_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  slot_free;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mkme_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mkme_pkg::ST_EXEC;
                end
            end
            mkme_pkg::ST_EXEC:
            begin
                state_next = mkme_pkg::ST_FINISH;
            end
            mkme_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = in_valid ? mkme_pkg::ST_EXEC : mkme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mkme_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.execute = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            mkme_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mkme_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            mkme_pkg::ST_FINISH:
            begin
                in_ready    = slot_free;
                cmd.publish = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.capture = in_valid && in_ready;
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mkme_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/mkme_datapath.sv -----
// Datapath: configuration, motion and button state, scaling multipliers, result register.
module mkme_datapath #(
    parameter int NUM_BUTTONS = mkme_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mkme_pkg::dp_cmd_t  cmd,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               mode,
    input  logic [4:0]         virtual_key,
    input  logic               key_down,
    input  logic               key_repeat,
    output logic [1:0]         report_kind,
    output logic [7:0]         button_mask,
    output logic signed [11:0] move_x,
    output logic signed [11:0] move_y,
    output logic signed [17:0] scroll_vertical,
    output logic signed [17:0] scroll_horizontal,
    output logic               tick_armed
);

    localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [5:0] BTN_KEY_END = 6'(int'(mkme_pkg::KEY_FIRST_BUTTON) + NUM_BUTTONS);

    // Saturating step of a signed 4-bit count toward +7 or -8.
    function automatic logic signed [3:0] sat_step(input logic signed [3:0] v, input logic up);
        logic signed [3:0] r;
        if (up)
        begin
            r = (v == 4'sb0111) ? v : v + 4'sd1;
        end
        else
        begin
            r = (v == 4'sb1000) ? v : v - 4'sd1;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [7:0] scale_limit_reg;
    logic [7:0] fast_pointer_scale_reg;
    logic [7:0] fast_scroll_scale_reg;
    logic [5:0] scroll_unit_reg;

    // Captured transaction.
    logic       mode_reg;
    logic [4:0] key_reg;
    logic       down_reg;
    logic       repeat_reg;

    // Engine state.
    logic signed [3:0] count_x_reg, count_x_next;
    logic signed [3:0] count_y_reg, count_y_next;
    logic [7:0]        accel_scale_reg, accel_scale_next;
    logic              scroll_mode_reg, scroll_mode_next;
    logic              high_speed_reg, high_speed_next;
    logic              armed_reg, armed_next;
    logic [3:0]        button_count_reg [NUM_BUTTONS];

    // Intermediate results between execute and publish.
    mkme_pkg::report_kind_t kind_reg, kind_next;
    logic signed [11:0]     prod_x_reg, prod_x_next;
    logic signed [11:0]     prod_y_reg, prod_y_next;

    // Result register.
    logic [1:0]         report_kind_reg;
    logic [7:0]         button_mask_reg;
    logic signed [11:0] move_x_reg, move_y_reg;
    logic signed [17:0] scroll_vertical_reg, scroll_horizontal_reg;
    logic               tick_armed_reg;

    logic                 is_button;
    logic [4:0]           btn_offset;
    logic [BTN_IDX_W-1:0] btn_idx;
    logic [3:0]           btn_count_cur;
    logic [3:0]           btn_count_new;
    logic                 btn_write;
    logic [7:0]           tick_scale;
    logic signed [12:0]   mul_x, mul_y;
    logic signed [18:0]   wheel_v, wheel_h;
    logic [7:0]           mask_now;
    logic signed [3:0]    cx_upd, cy_upd;

    assign is_button     = ({1'b0, key_reg} >= {1'b0, mkme_pkg::KEY_FIRST_BUTTON})
                           && ({1'b0, key_reg} < BTN_KEY_END);
    assign btn_offset    = key_reg - mkme_pkg::KEY_FIRST_BUTTON;
    assign btn_idx       = btn_offset[BTN_IDX_W-1:0];
    assign btn_count_cur = button_count_reg[btn_idx];

    always_comb
    begin
        if (scroll_mode_reg)
        begin
            tick_scale = high_speed_reg ? fast_scroll_scale_reg : accel_scale_reg;
        end
        else
        begin
            tick_scale = high_speed_reg ? fast_pointer_scale_reg : accel_scale_reg;
        end
        mul_x = {{9{count_x_reg[3]}}, count_x_reg} * $signed({5'b0, tick_scale});
        mul_y = {{9{count_y_reg[3]}}, count_y_reg} * $signed({5'b0, tick_scale});
    end

    // State update for one transaction, used in the execute step.
    always_comb
    begin
        count_x_next     = count_x_reg;
        count_y_next     = count_y_reg;
        accel_scale_next = accel_scale_reg;
        scroll_mode_next = scroll_mode_reg;
        high_speed_next  = high_speed_reg;
        armed_next       = armed_reg;
        kind_next        = mkme_pkg::KIND_NONE;
        prod_x_next      = '0;
        prod_y_next      = '0;
        btn_write        = 1'b0;
        btn_count_new    = btn_count_cur;
        cx_upd           = count_x_reg;
        cy_upd           = count_y_reg;

        if (mode_reg == mkme_pkg::MODE_TICK)
        begin
            if (armed_reg)
            begin
                prod_x_next = mul_x[11:0];
                prod_y_next = mul_y[11:0];
                kind_next   = scroll_mode_reg ? mkme_pkg::KIND_SCROLL
                                              : mkme_pkg::KIND_POINTER;
                if (accel_scale_reg < scale_limit_reg)
                begin
                    accel_scale_next = accel_scale_reg + 8'd1;
                end
            end
        end
        else if (is_button)
        begin
            if (!repeat_reg)
            begin
                btn_write = 1'b1;
                if (down_reg)
                begin
                    btn_count_new = (btn_count_cur == 4'hF) ? btn_count_cur
                                                            : btn_count_cur + 4'd1;
                end
                else
                begin
                    btn_count_new = (btn_count_cur == 4'h0) ? btn_count_cur
                                                            : btn_count_cur - 4'd1;
                end
                kind_next = mkme_pkg::KIND_POINTER;
            end
        end
        else if (key_reg <= mkme_pkg::KEY_HIGH_SPEED)
        begin
            if (!repeat_reg)
            begin
                if (key_reg == mkme_pkg::KEY_HIGH_SPEED)
                begin
                    high_speed_next = down_reg;
                end
                else
                begin
                    // Up and left step down on press; down and right step up.
                    if (key_reg[1])
                    begin
                        cx_upd = sat_step(count_x_reg, key_reg[0] == down_reg);
                    end
                    else
                    begin
                        cy_upd = sat_step(count_y_reg, key_reg[0] == down_reg);
                    end
                    if (down_reg)
                    begin
                        scroll_mode_next = key_reg[2];
                    end
                end
            end
            count_x_next = cx_upd;
            count_y_next = cy_upd;
            if ((cx_upd != 4'sd0) || (cy_upd != 4'sd0))
            begin
                armed_next = 1'b1;
            end
            else
            begin
                armed_next       = 1'b0;
                accel_scale_next = 8'd1;
            end
        end
    end

    // Wheel deltas are the negated products scaled by the scroll unit.
    always_comb
    begin
        wheel_v = -({{7{prod_y_reg[11]}}, prod_y_reg} * $signed({13'b0, scroll_unit_reg}));
        wheel_h = -({{7{prod_x_reg[11]}}, prod_x_reg} * $signed({13'b0, scroll_unit_reg}));
    end

    always_comb
    begin
        mask_now = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < NUM_BUTTONS)
            begin
                mask_now[b] = |button_count_reg[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_limit_reg        <= mkme_pkg::SCALE_LIMIT_RESET;
            fast_pointer_scale_reg <= mkme_pkg::FAST_POINTER_SCALE_RESET;
            fast_scroll_scale_reg  <= mkme_pkg::FAST_SCROLL_SCALE_RESET;
            scroll_unit_reg        <= mkme_pkg::SCROLL_UNIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mkme_pkg::CFG_SCALE_LIMIT:        scale_limit_reg        <= cfg_data;
                mkme_pkg::CFG_FAST_POINTER_SCALE: fast_pointer_scale_reg <= cfg_data;
                mkme_pkg::CFG_FAST_SCROLL_SCALE:  fast_scroll_scale_reg  <= cfg_data;
                mkme_pkg::CFG_SCROLL_UNIT:        scroll_unit_reg        <= cfg_data[5:0];
                default:                          scroll_unit_reg        <= scroll_unit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_x_reg     <= '0;
            count_y_reg     <= '0;
            accel_scale_reg <= 8'd1;
            scroll_mode_reg <= 1'b0;
            high_speed_reg  <= 1'b0;
            armed_reg       <= 1'b0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                button_count_reg[b] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            count_x_reg     <= count_x_next;
            count_y_reg     <= count_y_next;
            accel_scale_reg <= accel_scale_next;
            scroll_mode_reg <= scroll_mode_next;
            high_speed_reg  <= high_speed_next;
            armed_reg       <= armed_next;
            if (btn_write)
            begin
                button_count_reg[btn_idx] <= btn_count_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            key_reg    <= virtual_key;
            down_reg   <= key_down;
            repeat_reg <= key_repeat;
        end
        if (cmd.execute)
        begin
            kind_reg   <= kind_next;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (cmd.publish)
        begin
            report_kind_reg <= kind_reg;
            button_mask_reg <= mask_now;
            tick_armed_reg  <= armed_reg;
            if (kind_reg == mkme_pkg::KIND_POINTER)
            begin
                move_x_reg <= prod_x_reg;
                move_y_reg <= prod_y_reg;
            end
            else
            begin
                move_x_reg <= '0;
                move_y_reg <= '0;
            end
            if (kind_reg == mkme_pkg::KIND_SCROLL)
            begin
                scroll_vertical_reg   <= wheel_v[17:0];
                scroll_horizontal_reg <= wheel_h[17:0];
            end
            else
            begin
                scroll_vertical_reg   <= '0;
                scroll_horizontal_reg <= '0;
            end
        end
    end

    assign report_kind       = report_kind_reg;
    assign button_mask       = button_mask_reg;
    assign move_x            = move_x_reg;
    assign move_y            = move_y_reg;
    assign scroll_vertical   = scroll_vertical_reg;
    assign scroll_horizontal = scroll_horizontal_reg;
    assign tick_armed        = tick_armed_reg;

endmodule

// ----- design/mouse_keys_motion_engine.sv -----
// Each accepted transaction passes through the execute step (state update,
// count-by-scale multiply) and the publish step (scroll-unit multiply into the
// output register) of the shared datapath; publish waits for a free output register,
// and while a transaction is in flight the next is taken only as it is published.
// Reset: rst_n is asynchronous and active low; it clears all motion and button
// state, loads the default configuration and empties the output register.
module mouse_keys_motion_engine #(
    parameter int NUM_BUTTONS = mkme_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write port.
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // Input transaction: a key event or a timer tick.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [4:0]         virtual_key,
    input  logic               key_down,
    input  logic               key_repeat,
    // Output transaction: one report per input transaction.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         report_kind,
    output logic [7:0]         button_mask,
    output logic signed [11:0] move_x,
    output logic signed [11:0] move_y,
    output logic signed [17:0] scroll_vertical,
    output logic signed [17:0] scroll_horizontal,
    output logic               tick_armed
);

    // The controller walks each transaction through capture, execute and
    // publish. While a finished result waits in the output register the
    // controller holds in the publish state; as soon as the register frees
    // up it loads the new result and takes the next transaction in the same
    // cycle, so back-to-back work proceeds without an idle state in between.
    mkme_pkg::dp_cmd_t cmd;

    mkme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the signed motion counts, the
    // acceleration scale, the per-button press counts and the result
    // register. Tick reports use the state as it stood before the tick;
    // the button mask and the armed flag show the state after the update.
    mkme_datapath #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mode              (mode),
        .virtual_key       (virtual_key),
        .key_down          (key_down),
        .key_repeat        (key_repeat),
        .report_kind       (report_kind),
        .button_mask       (button_mask),
        .move_x            (move_x),
        .move_y            (move_y),
        .scroll_vertical   (scroll_vertical),
        .scroll_horizontal (scroll_horizontal),
        .tick_armed        (tick_armed)
    );

endmodule

// ----- tb/sv/tb_mouse_keys_motion_engine.sv -----
// Self-checking testbench for the mouse-keys motion engine, with its own prediction of every report.
module tb_mouse_keys_motion_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import mkme_pkg::*;

    localparam int N_BUTTONS = NUM_BUTTONS_DEFAULT;

    // Input modes and virtual-key codes used by the stimulus.
    localparam logic       MODE_KEY         = 1'b0;
    localparam logic [4:0] KEY_UP           = 5'd0;
    localparam logic [4:0] KEY_DOWN         = 5'd1;
    localparam logic [4:0] KEY_LEFT         = 5'd2;
    localparam logic [4:0] KEY_RIGHT        = 5'd3;
    localparam logic [4:0] KEY_SCROLL_UP    = 5'd4;
    localparam logic [4:0] KEY_SCROLL_DOWN  = 5'd5;
    localparam logic [4:0] KEY_SCROLL_LEFT  = 5'd6;
    localparam logic [4:0] KEY_SCROLL_RIGHT = 5'd7;
    localparam logic [4:0] KEY_LAST_BUTTON  = KEY_FIRST_BUTTON + 5'(N_BUTTONS - 1);
    localparam logic [4:0] KEY_PAST_BUTTONS = KEY_FIRST_BUTTON + 5'(N_BUTTONS);
    localparam logic [4:0] KEY_UNUSED_TOP   = 5'd31;

    // Direction codes, taken from the low two bits of a move or scroll key.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    // Cycles to let pass once nothing is outstanding.
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic       mode;
        logic [4:0] vkey;
        logic       down;
        logic       rep;
    } key_item_t;

    typedef struct packed {
        report_kind_t       kind;
        logic [7:0]         mask;
        logic signed [11:0] mx;
        logic signed [11:0] my;
        logic signed [17:0] sv;
        logic signed [17:0] sh;
        logic               armed;
    } report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = CFG_SCALE_LIMIT;
    logic [7:0]         cfg_data = 8'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = MODE_KEY;
    logic [4:0]         virtual_key = KEY_UP;
    logic               key_down = 1'b0;
    logic               key_repeat = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         report_kind;
    logic [7:0]         button_mask;
    logic signed [11:0] move_x;
    logic signed [11:0] move_y;
    logic signed [17:0] scroll_vertical;
    logic signed [17:0] scroll_horizontal;
    logic               tick_armed;

    mouse_keys_motion_engine #(
        .NUM_BUTTONS(N_BUTTONS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .virtual_key      (virtual_key),
        .key_down         (key_down),
        .key_repeat       (key_repeat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .report_kind      (report_kind),
        .button_mask      (button_mask),
        .move_x           (move_x),
        .move_y           (move_y),
        .scroll_vertical  (scroll_vertical),
        .scroll_horizontal(scroll_horizontal),
        .tick_armed       (tick_armed)
    );

    // A 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Key events waiting to be driven, and reports predicted but not yet seen.
    key_item_t queued_keys[$];
    report_t   pending_reports[$];
    key_item_t driven_key;

    // Idle and stall rates in percent, changed between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int n_errors = 0;
    int n_accepted = 0;
    int n_pointer = 0;
    int n_scroll = 0;
    int n_quiet = 0;
    int n_saturated = 0;

    // The predictor keeps its own copy of the configuration registers.
    logic [7:0] cfg_scale_limit = SCALE_LIMIT_RESET;
    logic [7:0] cfg_fast_pointer = FAST_POINTER_SCALE_RESET;
    logic [7:0] cfg_fast_scroll = FAST_SCROLL_SCALE_RESET;
    logic [5:0] cfg_unit = SCROLL_UNIT_RESET;

    // Predicted engine state, at its reset values.
    logic signed [3:0] eng_cx = 4'sd0;
    logic signed [3:0] eng_cy = 4'sd0;
    logic [7:0]        eng_scale = 8'd1;
    logic              eng_scroll = 1'b0;
    logic              eng_fast = 1'b0;
    logic              eng_armed = 1'b0;
    logic [3:0]        eng_buttons [N_BUTTONS] = '{default: 4'd0};

    // Clamps a motion count to the signed four-bit range and notes when it hits a limit.
    function automatic logic signed [3:0] clamp_count(input int v);
        if (v > 7)
        begin
            n_saturated++;
            return 4'sd7;
        end
        if (v < -8)
        begin
            n_saturated++;
            return -4'sd8;
        end
        return v[3:0];
    endfunction

    // Applies one accepted transaction to the predicted state and returns the report it yields.
    function automatic report_t advance_engine(input key_item_t it);
        report_t r;
        int      s;
        int      cx;
        int      cy;
        int      unit;
        int      d;
        int      b;
        r = '0;
        r.kind = KIND_NONE;
        cx = int'(eng_cx);
        cy = int'(eng_cy);
        unit = int'(cfg_unit);
        if (it.mode == MODE_TICK)
        begin
            if (eng_armed)
            begin
                if (!eng_scroll)
                begin
                    s = eng_fast ? int'(cfg_fast_pointer) : int'(eng_scale);
                    r.mx = 12'(cx * s);
                    r.my = 12'(cy * s);
                    r.kind = KIND_POINTER;
                end
                else
                begin
                    s = eng_fast ? int'(cfg_fast_scroll) : int'(eng_scale);
                    r.sv = 18'(-cy * s * unit);
                    r.sh = 18'(-cx * s * unit);
                    r.kind = KIND_SCROLL;
                end
                // The scale never moves down here, even when the limit lies below it.
                if (eng_scale < cfg_scale_limit)
                    eng_scale = eng_scale + 8'd1;
            end
        end
        else if (it.vkey >= KEY_FIRST_BUTTON && int'(it.vkey) < int'(KEY_FIRST_BUTTON) + N_BUTTONS)
        begin
            if (!it.rep)
            begin
                b = int'(it.vkey - KEY_FIRST_BUTTON);
                if (it.down)
                begin
                    if (eng_buttons[b] < 4'd15)
                        eng_buttons[b] = eng_buttons[b] + 4'd1;
                    else
                        n_saturated++;
                end
                else if (eng_buttons[b] > 4'd0)
                    eng_buttons[b] = eng_buttons[b] - 4'd1;
                r.kind = KIND_POINTER;
            end
        end
        else if (it.vkey <= KEY_HIGH_SPEED)
        begin
            if (!it.rep)
            begin
                if (it.vkey == KEY_HIGH_SPEED)
                    eng_fast = it.down;
                else
                begin
                    d = it.down ? 1 : -1;
                    case (it.vkey[1:0])
                        DIR_UP:   eng_cy = clamp_count(cy - d);
                        DIR_DOWN: eng_cy = clamp_count(cy + d);
                        DIR_LEFT: eng_cx = clamp_count(cx - d);
                        default:  eng_cx = clamp_count(cx + d);
                    endcase
                    if (it.down)
                        eng_scroll = (it.vkey >= KEY_SCROLL_UP);
                end
            end
            // Repeats also re-evaluate arming.
            if (eng_cx != 0 || eng_cy != 0)
                eng_armed = 1'b1;
            else
            begin
                eng_scale = 8'd1;
                eng_armed = 1'b0;
            end
        end
        for (b = 0; b < N_BUTTONS && b < 8; b++)
            r.mask[b] = (eng_buttons[b] != 4'd0);
        r.armed = eng_armed;
        return r;
    endfunction

    // Driver: presents queued key events, idling at random between transactions.
    // The prediction is made at the edge that accepts a transaction, so the expected
    // report is in place well before the block can deliver it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_reports.insert(pending_reports.size(), advance_engine(driven_key));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (queued_keys.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    driven_key = queued_keys.pop_front();
                    in_valid <= 1'b1;
                    mode <= driven_key.mode;
                    virtual_key <= driven_key.vkey;
                    key_down <= driven_key.down;
                    key_repeat <= driven_key.rep;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [17:0] want, input logic [17:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Monitor: stalls the output at random and checks each report against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    n_errors++;
                    $display("%0t ns: report with no prediction waiting, kind %0d", $time,
                             report_kind);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("report_kind", 18'(want.kind), 18'(report_kind));
                    check_field("button_mask", 18'(want.mask), 18'(button_mask));
                    check_field("move_x", 18'(want.mx), 18'(move_x));
                    check_field("move_y", 18'(want.my), 18'(move_y));
                    check_field("scroll_vertical", want.sv, scroll_vertical);
                    check_field("scroll_horizontal", want.sh, scroll_horizontal);
                    check_field("tick_armed", 18'(want.armed), 18'(tick_armed));
                    case (want.kind)
                        KIND_POINTER: n_pointer++;
                        KIND_SCROLL:  n_scroll++;
                        default:      n_quiet++;
                    endcase
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_key(input logic m, input logic [4:0] k, input logic dn, input logic rp);
        key_item_t it;
        it = '{mode: m, vkey: k, down: dn, rep: rp};
        queued_keys.insert(queued_keys.size(), it);
    endtask

    // Mostly move, scroll, button and tick traffic; a few unknown keys as noise.
    // down_pct steers the counts toward their limits or back toward zero.
    function automatic key_item_t random_key(input int down_pct);
        key_item_t it;
        int        pick;
        pick = $urandom_range(99);
        it.mode = MODE_KEY;
        it.vkey = 5'($urandom_range(7));
        it.down = ($urandom_range(99) < down_pct);
        it.rep = ($urandom_range(99) < 12);
        if (pick < 35)
        begin
            // A tick ignores its other fields, so they are left random.
            it.mode = MODE_TICK;
            it.vkey = 5'($urandom);
            it.down = 1'($urandom);
            it.rep = 1'($urandom);
        end
        else if (pick < 65)
            ;
        else if (pick < 72)
            it.vkey = KEY_HIGH_SPEED;
        else if (pick < 93)
            it.vkey = KEY_FIRST_BUTTON + 5'($urandom_range(N_BUTTONS - 1));
        else
            it.vkey = 5'($urandom_range(31));
        return it;
    endfunction

    // Waits until every queued event has been accepted and every report has arrived.
    task automatic drain;
        while (queued_keys.size() != 0 || in_valid || pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SCALE_LIMIT:        cfg_scale_limit = val;
            CFG_FAST_POINTER_SCALE: cfg_fast_pointer = val;
            CFG_FAST_SCROLL_SCALE:  cfg_fast_scroll = val;
            default:                cfg_unit = val[5:0];
        endcase
    endtask

    // One phase: settle, load all four registers, set the idle rates, then queue random traffic.
    // Waiting for the block to empty before each phase also gives the sender a full pause.
    task automatic run_phase(input int limit, input int fast_ptr, input int fast_scr,
                             input int unit, input int send_pct, input int recv_pct,
                             input int down_pct, input int n);
        int i;
        drain();
        write_register(CFG_SCALE_LIMIT, 8'(limit));
        write_register(CFG_FAST_POINTER_SCALE, 8'(fast_ptr));
        write_register(CFG_FAST_SCROLL_SCALE, 8'(fast_scr));
        write_register(CFG_SCROLL_UNIT, 8'(unit));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < n; i++)
            queued_keys.insert(queued_keys.size(), random_key(down_pct));
    endtask

    // Main sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset configuration, without idling.
        queue_key(MODE_TICK, KEY_UNUSED_TOP, 1'b1, 1'b1);     // tick while disarmed
        queue_key(MODE_KEY, KEY_UNUSED_TOP, 1'b1, 1'b0);      // unknown keys are ignored
        queue_key(MODE_KEY, KEY_PAST_BUTTONS, 1'b0, 1'b1);
        queue_key(MODE_KEY, KEY_UP, 1'b1, 1'b1);              // repeat changes nothing
        queue_key(MODE_KEY, KEY_RIGHT, 1'b1, 1'b0);           // arms the tick in pointer mode
        queue_key(MODE_TICK, KEY_UP, 1'b0, 1'b0);
        queue_key(MODE_TICK, KEY_UP, 1'b0, 1'b0);             // scale has grown
        queue_key(MODE_KEY, KEY_HIGH_SPEED, 1'b1, 1'b0);
        queue_key(MODE_TICK, KEY_UP, 1'b0, 1'b0);             // fast pointer scale
        queue_key(MODE_KEY, KEY_SCROLL_UP, 1'b1, 1'b0);       // switches to scroll mode
        queue_key(MODE_TICK, KEY_UP, 1'b0, 1'b0);             // fast scroll scale
        queue_key(MODE_KEY, KEY_HIGH_SPEED, 1'b0, 1'b0);
        queue_key(MODE_TICK, KEY_UP, 1'b0, 1'b0);
        queue_key(MODE_KEY, KEY_FIRST_BUTTON, 1'b1, 1'b0);
        queue_key(MODE_KEY, KEY_LAST_BUTTON, 1'b1, 1'b0);
        queue_key(MODE_KEY, KEY_LAST_BUTTON, 1'b1, 1'b1);     // button repeat gives a report of kind none
        queue_key(MODE_KEY, KEY_LAST_BUTTON, 1'b0, 1'b0);
        queue_key(MODE_KEY, KEY_FIRST_BUTTON, 1'b0, 1'b0);
        queue_key(MODE_KEY, KEY_FIRST_BUTTON, 1'b0, 1'b0);    // count stays at zero
        queue_key(MODE_KEY, KEY_SCROLL_DOWN, 1'b1, 1'b0);     // vertical count back to zero
        queue_key(MODE_KEY, KEY_SCROLL_LEFT, 1'b1, 1'b0);
        queue_key(MODE_KEY, KEY_SCROLL_RIGHT, 1'b1, 1'b0);
        queue_key(MODE_KEY, KEY_LEFT, 1'b1, 1'b0);            // both zero: disarm, scale 1
        queue_key(MODE_KEY, KEY_DOWN, 1'b0, 1'b1);
        queue_key(MODE_TICK, KEY_UP, 1'b0, 1'b0);

        // Random phases, from the register maxima to the minima, then random settings and the reset values.
        run_phase(255, 255, 255, 63, 0, 0, 75, 120);
        run_phase(1, 1, 1, 1, 69, 0, 55, 120);
        run_phase($urandom_range(2, 40), $urandom_range(1, 255), $urandom_range(1, 255),
                  $urandom_range(1, 63), 0, 69, 88, 150);
        run_phase($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255),
                  $urandom_range(1, 63), 25, 25, 30, 150);
        run_phase(int'(SCALE_LIMIT_RESET), int'(FAST_POINTER_SCALE_RESET),
                  int'(FAST_SCROLL_SCALE_RESET), int'(SCROLL_UNIT_RESET),
                  0, 0, 50, 160);
        drain();

        $display("Covered %0d transactions over six phases and five register settings.",
                 n_accepted);
        $display("Reports: %0d pointer, %0d scroll, %0d quiet; %0d saturating updates.",
                 n_pointer, n_scroll, n_quiet, n_saturated);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
